/* hdl/nsrf_pkg.sv */
package nsrf_pkg;

  localparam int LINE_BYTES = 128;
  localparam int ADDR_W     = $clog2(LINE_BYTES);
  localparam int LEN_W      = $clog2(LINE_BYTES + 1);

  localparam logic [7:0] NL_CHAR     = 8'h0A;
  localparam logic [7:0] DOLLAR_CHAR = 8'h24;
  localparam logic [7:0] STAR_CHAR   = 8'h2A;

  localparam logic [23:0] MATCH_TAG_RST    = 24'h484447;
  localparam logic [7:0]  REPLACE_CHAR_RST = 8'h54;

  // tag sits at '$'+3 .. '$'+5
  localparam int TAG_OFS = 3;

  localparam logic REG_MATCH_TAG    = 1'b0;
  localparam logic REG_REPLACE_CHAR = 1'b1;

  // read address select
  localparam logic [2:0] RD_STAR1 = 3'd0;
  localparam logic [2:0] RD_STAR2 = 3'd1;
  localparam logic [2:0] RD_TAG0  = 3'd2;
  localparam logic [2:0] RD_TAG1  = 3'd3;
  localparam logic [2:0] RD_TAG2  = 3'd4;
  localparam logic [2:0] RD_PTR   = 3'd5;

  typedef struct packed {
    logic       collect;
    logic       clear;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       cap_hi;
    logic       cap_tag0;
    logic       cap_tag1;
    logic       do_retag;
    logic       wr_hi;
    logic       wr_lo;
    logic       fill_issue;
    logic       load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic newline;
    logic pre_ok;
    logic hex_ok;
    logic tag_in_body;
    logic tag_match;
    logic fill_done;
    logic at_end;
    logic out_free;
  } dp_stat_t;

  // 0..15 for a hex digit, bit 4 set otherwise
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
    return v;
  endfunction

  function automatic logic [7:0] hex_upper(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = 8'h30 + {4'h0, n};
    else c = 8'h41 + {4'h0, n} - 8'd10;
    return c;
  endfunction

endpackage

/* hdl/nsrf_ram.sv */
module nsrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/nsrf_ctrl.sv */
module nsrf_ctrl
  import nsrf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  dp_stat_t  stat,
  output logic      in_ready,
  output ctrl_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_HEX1   = 4'd2;
  localparam logic [3:0] S_HEX2   = 4'd3;
  localparam logic [3:0] S_TAG0   = 4'd4;
  localparam logic [3:0] S_TAG1   = 4'd5;
  localparam logic [3:0] S_TAG2   = 4'd6;
  localparam logic [3:0] S_WR1    = 4'd7;
  localparam logic [3:0] S_WR2    = 4'd8;
  localparam logic [3:0] S_FILL   = 4'd9;
  localparam logic [3:0] S_SETTLE = 4'd10;
  localparam logic [3:0] S_LOAD   = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.collect = 1'b1;
          if (stat.newline) state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.pre_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_STAR1;
          state_nxt  = S_HEX1;
        end else begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_HEX1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_STAR2;
        cmd.cap_hi = 1'b1;
        state_nxt  = S_HEX2;
      end
      S_HEX2: begin
        if (!stat.hex_ok) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.tag_in_body) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_TAG0;
          state_nxt  = S_TAG0;
        end else begin
          state_nxt = S_FILL;
        end
      end
      S_TAG0: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_TAG1;
        cmd.cap_tag0 = 1'b1;
        state_nxt    = S_TAG1;
      end
      S_TAG1: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_TAG2;
        cmd.cap_tag1 = 1'b1;
        state_nxt    = S_TAG2;
      end
      S_TAG2: begin
        if (stat.tag_match) begin
          cmd.do_retag = 1'b1;
          state_nxt    = S_WR1;
        end else begin
          state_nxt = S_FILL;
        end
      end
      S_WR1: begin
        cmd.wr_hi = 1'b1;
        state_nxt = S_WR2;
      end
      S_WR2: begin
        cmd.wr_lo = 1'b1;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = RD_PTR;
        cmd.fill_issue = 1'b1;
        if (stat.fill_done) state_nxt = S_SETTLE;
      end
      S_SETTLE: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // hold the group until the output register frees up
        if (stat.out_free) begin
          cmd.load = 1'b1;
          if (stat.at_end) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_FILL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/nsrf_dp.sv */
module nsrf_dp
  import nsrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  input  logic [7:0]  in_byte,
  input  logic [23:0] match_tag,
  input  logic [7:0]  replace_char,
  input  logic        out_ready,
  output dp_stat_t    stat,
  output logic        out_valid,
  output logic [7:0]  out_byte0,
  output logic [7:0]  out_byte1,
  output logic [7:0]  out_byte2,
  output logic [7:0]  out_byte3,
  output logic [2:0]  byte_count,
  output logic        last_group,
  output logic        retagged
);

  logic [LEN_W-1:0]  len_r;
  logic [ADDR_W-1:0] dollar_r;
  logic [ADDR_W-1:0] star_r;
  logic [7:0]        xor_r;
  logic              seen_d_r;
  logic              seen_s_r;
  logic              ovf_r;
  logic              tagged_r;
  logic [7:0]        hi_r;
  logic              m0_r;
  logic              m1_r;
  logic [LEN_W-1:0]  ptr_r;
  logic [2:0]        fill_cnt_r;
  logic              pend_r;
  logic [1:0]        pend_slot_r;
  logic [7:0]        stg_r [4];
  logic              out_valid_r;
  logic [7:0]        ob_r [4];
  logic [2:0]        cnt_r;
  logic              last_r;
  logic              rtg_r;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  logic              can_store;
  logic [LEN_W+1:0]  star_p2;
  logic [LEN_W+1:0]  len_m1;
  logic [LEN_W+1:0]  dol_p5;
  logic [4:0]        hv_hi;
  logic [4:0]        hv_lo;
  logic [7:0]        xor_new;
  logic [ADDR_W-1:0] tag_base;

  assign can_store = !ovf_r && (len_r < LEN_W'(LINE_BYTES));
  assign tag_base  = dollar_r + ADDR_W'(TAG_OFS);
  assign xor_new   = xor_r ^ rdata ^ replace_char;

  always_comb begin
    we    = 1'b0;
    waddr = len_r[ADDR_W-1:0];
    wdata = in_byte;
    if (cmd.collect) begin
      we = can_store;
    end else if (cmd.do_retag) begin
      we    = 1'b1;
      waddr = tag_base + ADDR_W'(2);
      wdata = replace_char;
    end else if (cmd.wr_hi) begin
      we    = 1'b1;
      waddr = star_r + ADDR_W'(1);
      wdata = hex_upper(xor_r[7:4]);
    end else if (cmd.wr_lo) begin
      we    = 1'b1;
      waddr = star_r + ADDR_W'(2);
      wdata = hex_upper(xor_r[3:0]);
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_STAR1: raddr = star_r + ADDR_W'(1);
      RD_STAR2: raddr = star_r + ADDR_W'(2);
      RD_TAG0:  raddr = tag_base;
      RD_TAG1:  raddr = tag_base + ADDR_W'(1);
      RD_TAG2:  raddr = tag_base + ADDR_W'(2);
      RD_PTR:   raddr = ptr_r[ADDR_W-1:0];
      default:  raddr = ptr_r[ADDR_W-1:0];
    endcase
  end

  nsrf_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_line_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign star_p2 = (LEN_W+2)'(star_r) + (LEN_W+2)'(2);
  assign len_m1  = (LEN_W+2)'(len_r) - (LEN_W+2)'(1);
  assign dol_p5  = (LEN_W+2)'(dollar_r) + (LEN_W+2)'(TAG_OFS + 2);
  assign hv_hi   = hex_value(hi_r);
  assign hv_lo   = hex_value(rdata);

  always_comb begin
    stat.newline     = (in_byte == NL_CHAR);
    stat.pre_ok      = !ovf_r && seen_d_r && seen_s_r && (star_p2 < len_m1);
    stat.hex_ok      = !hv_hi[4] && !hv_lo[4] && ({hv_hi[3:0], hv_lo[3:0]} == xor_r);
    stat.tag_in_body = dol_p5 < (LEN_W+2)'(star_r);
    stat.tag_match   = m0_r && m1_r && (rdata == match_tag[7:0]);
    stat.fill_done   = (fill_cnt_r == 3'd3) || (ptr_r + LEN_W'(1) == len_r);
    stat.at_end      = (ptr_r == len_r);
    stat.out_free    = !out_valid_r || out_ready;
  end

  // line bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      len_r      <= '0;
      dollar_r   <= '0;
      star_r     <= '0;
      xor_r      <= '0;
      seen_d_r   <= 1'b0;
      seen_s_r   <= 1'b0;
      ovf_r      <= 1'b0;
      tagged_r   <= 1'b0;
      ptr_r      <= '0;
      fill_cnt_r <= '0;
      pend_r     <= 1'b0;
    end else begin
      if (cmd.collect && !ovf_r) begin
        if (can_store) begin
          len_r <= len_r + LEN_W'(1);
          if (in_byte != NL_CHAR) begin
            if (!seen_d_r) begin
              if (in_byte == DOLLAR_CHAR) begin
                seen_d_r <= 1'b1;
                dollar_r <= len_r[ADDR_W-1:0];
              end
            end else if (!seen_s_r) begin
              if (in_byte == STAR_CHAR) begin
                seen_s_r <= 1'b1;
                star_r   <= len_r[ADDR_W-1:0];
              end else begin
                xor_r <= xor_r ^ in_byte;
              end
            end
          end
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.do_retag) begin
        xor_r    <= xor_new;
        tagged_r <= 1'b1;
      end
      pend_r <= cmd.fill_issue;
      if (cmd.fill_issue) begin
        ptr_r       <= ptr_r + LEN_W'(1);
        fill_cnt_r  <= fill_cnt_r + 3'd1;
        pend_slot_r <= fill_cnt_r[1:0];
      end
      if (cmd.load) begin
        fill_cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_hi) hi_r <= rdata;
    if (cmd.cap_tag0) m0_r <= (rdata == match_tag[23:16]);
    if (cmd.cap_tag1) m1_r <= (rdata == match_tag[15:8]);
    if (pend_r) stg_r[pend_slot_r] <= rdata;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 4; k++) begin
        ob_r[k] <= (3'(k) < fill_cnt_r) ? stg_r[k] : 8'h00;
      end
      cnt_r  <= fill_cnt_r;
      last_r <= stat.at_end;
      rtg_r  <= tagged_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte0  = ob_r[0];
  assign out_byte1  = ob_r[1];
  assign out_byte2  = ob_r[2];
  assign out_byte3  = ob_r[3];
  assign byte_count = cnt_r;
  assign last_group = last_r;
  assign retagged   = rtg_r;

endmodule

/* hdl/nmea_sentence_retag_filter.sv */
// Input: one byte per cycle while a line is collected; in_ready stays low from
// the newline until the last group is loaded or the line is dropped, longer
// while out_ready stalls. After the newline the checksum is checked, then a
// tag in the body is compared and, on a match, rewritten, then the line is
// read out in groups of four bytes through the one read port.
// Sync active-low reset clears line state, out_valid and config (HDG, 'T').
module nmea_sentence_retag_filter
  import nsrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte0,
  output logic [7:0]  out_byte1,
  output logic [7:0]  out_byte2,
  output logic [7:0]  out_byte3,
  output logic [2:0]  out_byte_count,
  output logic        out_last_group,
  output logic        out_retagged,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ctrl_cmd_t   cmd;
  dp_stat_t    stat;
  logic [23:0] match_tag_r;
  logic [7:0]  replace_char_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_tag_r    <= MATCH_TAG_RST;
      replace_char_r <= REPLACE_CHAR_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MATCH_TAG) match_tag_r <= pwdata[23:0];
      else replace_char_r <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_REPLACE_CHAR) ? {24'h0, replace_char_r}
                                                 : {8'h0, match_tag_r};

  nsrf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  nsrf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_byte      (in_byte),
    .match_tag    (match_tag_r),
    .replace_char (replace_char_r),
    .out_ready    (out_ready),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_byte0    (out_byte0),
    .out_byte1    (out_byte1),
    .out_byte2    (out_byte2),
    .out_byte3    (out_byte3),
    .byte_count   (out_byte_count),
    .last_group   (out_last_group),
    .retagged     (out_retagged)
  );

endmodule

/* hdl/nsrf_checker.sv */
module nsrf_checker
  import nsrf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte3,
  input logic [2:0] out_byte_count,
  input logic       out_last_group
);

  // a pending request stays up until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped before it was taken");

  // reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result request present after reset");

  // only the group holding the newline may be short
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_count != 3'd4 |-> out_last_group && out_byte_count != 3'd0)
    else $error("short or empty group before the end of the line");

  // in a short group, byte position 3 reads as zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_count != 3'd4 |-> out_byte3 == 8'h00)
    else $error("byte beyond the group count is not zero");

  // a full group with the newline must end in the newline character
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_group && out_byte_count == 3'd4 |-> out_byte3 == NL_CHAR)
    else $error("last full group does not end in a newline");

endmodule

bind nmea_sentence_retag_filter nsrf_checker u_nsrf_checker (.*);

/* bench/nmea_sentence_retag_filter_tb.sv */
module nmea_sentence_retag_filter_tb
  import nsrf_pkg::*;
();

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;

  typedef logic [7:0] octet_t;

  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      count;
    logic            last;
    logic            rtg;
  } group_t;

  typedef enum int {
    CLEAN, NO_DOLLAR, NO_STAR, BAD_SUM, SHORT_SUM, BAD_HEX, LOWER_HEX, PREFIX, TRAILER, NOISE
  } flaw_t;

  class line_board_t;
    octet_t      line_buf [LINE_BYTES];
    int unsigned line_len;
    int unsigned dollar_pos;
    int unsigned star_pos;
    octet_t      csum;
    bit          got_dollar;
    bit          got_star;
    bit          too_long;
    logic [23:0] match_tag;
    octet_t      replace_char;
    group_t      groups_due[$];
    int          mismatches;

    function new();
      match_tag = MATCH_TAG_RST;
      replace_char = REPLACE_CHAR_RST;
      mismatches = 0;
      start_line();
    endfunction

    function void start_line();
      line_len = 0;
      dollar_pos = 0;
      star_pos = 0;
      csum = 8'h00;
      got_dollar = 1'b0;
      got_star = 1'b0;
      too_long = 1'b0;
    endfunction

    static function octet_t hex_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) return 8'h30 + {4'h0, n};
      return (lower ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
    endfunction

    function int digit_val(input octet_t c);
      if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
      if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
      return 16;
    endfunction

    function bit sum_ok();
      int hi;
      int lo;
      if (!got_dollar || !got_star) return 1'b0;
      // both digits must sit before the newline
      if (star_pos + 2 >= line_len - 1) return 1'b0;
      hi = digit_val(line_buf[star_pos + 1]);
      lo = digit_val(line_buf[star_pos + 2]);
      if (hi > 15 || lo > 15) return 1'b0;
      return ((hi << 4) | lo) == int'(csum);
    endfunction

    function bit retag();
      int unsigned p;
      octet_t old;
      p = dollar_pos + 3;
      if (dollar_pos + 5 >= star_pos) return 1'b0;
      if (line_buf[p] != match_tag[23:16] || line_buf[p + 1] != match_tag[15:8] ||
          line_buf[p + 2] != match_tag[7:0]) return 1'b0;
      old = line_buf[p + 2];
      line_buf[p + 2] = replace_char;
      csum = csum ^ old ^ replace_char;
      line_buf[star_pos + 1] = hex_char(csum[7:4], 1'b0);
      line_buf[star_pos + 2] = hex_char(csum[3:0], 1'b0);
      return 1'b1;
    endfunction

    function void take_byte(input octet_t b);
      bit line_rtg;
      int unsigned ngroups;
      int unsigned cnt;
      int unsigned g;
      int unsigned k;
      group_t grp;
      if (!too_long) begin
        if (line_len < LINE_BYTES) begin
          line_buf[line_len] = b;
          if (b != NL_CHAR) begin
            if (!got_dollar) begin
              if (b == DOLLAR_CHAR) begin
                got_dollar = 1'b1;
                dollar_pos = line_len;
              end
            end else if (!got_star) begin
              if (b == STAR_CHAR) begin
                got_star = 1'b1;
                star_pos = line_len;
              end else begin
                csum = csum ^ b;
              end
            end
          end
          line_len++;
        end else begin
          too_long = 1'b1;
        end
      end
      if (b != NL_CHAR) return;
      // drop the line
      if (too_long || !sum_ok()) begin
        start_line();
        return;
      end
      line_rtg = retag();
      ngroups = (line_len + 3) / 4;
      for (g = 0; g < ngroups; g++) begin
        cnt = line_len - g * 4;
        if (cnt > 4) cnt = 4;
        grp.data = '0;
        for (k = 0; k < cnt; k++) grp.data[k] = line_buf[g * 4 + k];
        grp.count = cnt[2:0];
        grp.last = (g + 1 == ngroups);
        grp.rtg = line_rtg;
        groups_due.push_back(grp);
      end
      start_line();
    endfunction

    task report(input string what);
      mismatches++;
      $display("mismatch: %s", what);
    endtask

    task check_group(input group_t got);
      group_t want;
      int k;
      if (groups_due.size() == 0) begin
        report($sformatf("group %h arrived with no line pending", got));
        return;
      end
      want = groups_due.pop_front();
      for (k = 0; k < 4; k++)
        if (got.data[k] !== want.data[k])
          report($sformatf("out_byte%0d got %h want %h", k, got.data[k], want.data[k]));
      if (got.count !== want.count)
        report($sformatf("out_byte_count got %0d want %0d", got.count, want.count));
      if (got.last !== want.last)
        report($sformatf("out_last_group got %b want %b", got.last, want.last));
      if (got.rtg !== want.rtg)
        report($sformatf("out_retagged got %b want %b", got.rtg, want.rtg));
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte0;
  logic [7:0]  out_byte1;
  logic [7:0]  out_byte2;
  logic [7:0]  out_byte3;
  logic [2:0]  out_byte_count;
  logic        out_last_group;
  logic        out_retagged;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  logic        hold_req = 1'b0;
  int          send_idle = 0;
  int          recv_stall = 0;
  octet_t      line_q[$];
  line_board_t board = new();

  nmea_sentence_retag_filter i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte0      (out_byte0),
    .out_byte1      (out_byte1),
    .out_byte2      (out_byte2),
    .out_byte3      (out_byte3),
    .out_byte_count (out_byte_count),
    .out_last_group (out_last_group),
    .out_retagged   (out_retagged),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : result_side
    group_t got;
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.data = {out_byte3, out_byte2, out_byte1, out_byte0};
        got.count = out_byte_count;
        got.last = out_last_group;
        got.rtg = out_retagged;
        board.check_group(got);
      end
      if (hold_req && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      // hold off long enough for the block to back up into its input
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic cfg_write(input logic reg_sel, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (reg_sel == REG_MATCH_TAG) board.match_tag = value[23:0];
    else board.replace_char = value[7:0];
  endtask

  task automatic set_config(input logic [23:0] tag, input octet_t ch);
    cfg_write(REG_MATCH_TAG, {8'h00, tag});
    cfg_write(REG_REPLACE_CHAR, {24'h0, ch});
  endtask

  task automatic send_byte(input octet_t b);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    // hold valid and payload until the request is taken
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_byte(b);
  endtask

  task automatic send_line();
    int i;
    for (i = 0; i < line_q.size(); i++) send_byte(line_q[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.groups_due.size() != 0) @(posedge clk);
    // let a dropped line finish its check before touching the registers
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic make_sentence(input int body_len, input bit with_tag, input flaw_t flaw);
    octet_t sum;
    octet_t c;
    octet_t hi;
    octet_t lo;
    logic [23:0] tag;
    int i;
    line_q.delete();
    sum = 8'h00;
    tag = board.match_tag;
    if (flaw == NOISE) begin
      repeat ($urandom_range(8, 1)) begin
        do c = 8'($urandom_range(255)); while (c == NL_CHAR);
        line_q.push_back(c);
      end
      line_q.push_back(NL_CHAR);
      return;
    end
    if (flaw == PREFIX) begin
      repeat ($urandom_range(3, 1)) begin
        do c = 8'($urandom_range(255)); while (c == NL_CHAR || c == DOLLAR_CHAR);
        line_q.push_back(c);
      end
    end
    if (flaw != NO_DOLLAR) line_q.push_back(DOLLAR_CHAR);
    for (i = 0; i < body_len; i++) begin
      if (with_tag && body_len >= 5 && i >= 2 && i <= 4) c = tag[8 * (4 - i) +: 8];
      else do c = 8'($urandom_range(255)); while (c == NL_CHAR || c == STAR_CHAR);
      sum = sum ^ c;
      line_q.push_back(c);
    end
    if (flaw == NO_STAR) begin
      line_q.push_back(NL_CHAR);
      return;
    end
    line_q.push_back(STAR_CHAR);
    if (flaw == BAD_SUM) sum = sum ^ 8'($urandom_range(255, 1));
    hi = line_board_t::hex_char(sum[7:4], flaw == LOWER_HEX);
    lo = line_board_t::hex_char(sum[3:0], flaw == LOWER_HEX);
    // 'G'..'Z' are never hex digits
    if (flaw == BAD_HEX) begin
      if ($urandom_range(1)) hi = 8'h47 + 8'($urandom_range(19));
      else lo = 8'h47 + 8'($urandom_range(19));
    end
    if (flaw == SHORT_SUM) begin
      if ($urandom_range(1)) line_q.push_back(hi);
    end else begin
      line_q.push_back(hi);
      line_q.push_back(lo);
    end
    if (flaw == TRAILER) begin
      repeat ($urandom_range(3, 1)) begin
        do c = 8'($urandom_range(255)); while (c == NL_CHAR);
        line_q.push_back(c);
      end
    end
    line_q.push_back(NL_CHAR);
  endtask

  task automatic run_phase(input logic [23:0] tag, input octet_t ch, input int idle,
                           input int stall, input int budget, input int long_len);
    int sent;
    flaw_t flaw;
    set_config(tag, ch);
    send_idle = idle;
    recv_stall = stall;
    if (long_len > 0) begin
      make_sentence(long_len - 5, 1'b1, CLEAN);
      send_line();
    end
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 65) flaw = CLEAN;
      else flaw = flaw_t'($urandom_range(int'(NOISE), int'(NO_DOLLAR)));
      make_sentence(int'($urandom_range(14)), 1'($urandom_range(1)), flaw);
      send_line();
      sent += line_q.size();
    end
    drain();
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_config(MATCH_TAG_RST, REPLACE_CHAR_RST);

    // tag match, empty body, extreme byte values
    make_sentence(5, 1'b1, CLEAN);
    send_line();
    make_sentence(0, 1'b0, CLEAN);
    send_line();
    line_q = '{DOLLAR_CHAR, 8'h00, 8'hFF, STAR_CHAR, 8'h46, 8'h46, NL_CHAR};
    send_line();
    drain();

    run_phase(24'hFFFFFF, 8'h00, 0, 0, 36, 0);
    // overflowing line, dropped
    run_phase(24'h000000, 8'hFF, 83, 0, 10, LINE_BYTES + 2);
    // line that just fills the store
    run_phase(24'h474741, 8'h58, 0, 83, 10, LINE_BYTES);
    run_phase(24'($urandom()), 8'($urandom_range(255)), 22, 22, 36, 0);
    hold_req <= 1'b1;
    run_phase(MATCH_TAG_RST, REPLACE_CHAR_RST, 0, 0, 36, 0);

    if (board.mismatches == 0 && board.groups_due.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
hdl/nsrf_pkg.sv
hdl/nsrf_ram.sv
hdl/nsrf_ctrl.sv
hdl/nsrf_dp.sv
hdl/nmea_sentence_retag_filter.sv
hdl/nsrf_checker.sv
bench/nmea_sentence_retag_filter_tb.sv
